// ===== rtl/core/dst_pkg.sv =====
package dst_pkg;

  typedef enum logic [3:0] {
    OP_ALLOC      = 4'd0,
    OP_ALLOC_DUP  = 4'd1,
    OP_COPY_TO    = 4'd2,
    OP_FREE       = 4'd3,
    OP_GET        = 4'd4,
    OP_SET_FLAGS  = 4'd5,
    OP_GET_FLAGS  = 4'd6,
    OP_NEXT       = 4'd7,
    OP_PREV       = 4'd8,
    OP_CLOSE_FROM = 4'd9,
    OP_EXEC_SWEEP = 4'd10,
    OP_CLEAR_ALL  = 4'd11
  } opcode_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_BADF  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [0:0] REG_ALLOWED = 1'b0;
  localparam logic [0:0] REG_EXEC    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the item, decode, start
    logic read;     // read data memory at slot_index
    logic scan;     // one walk step
    logic finish;   // compute result, commit state
    logic out_pop;  // result taken
  } dst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dst_sts_t;

endpackage

// ===== rtl/core/dst_ctrl.sv =====
module dst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dst_pkg::dst_sts_t sts_i,
  output dst_pkg::dst_cmd_t cmd_o
);

  dst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dst_pkg::S_IDLE: if (in_valid_i) state_d = dst_pkg::S_READ;
      dst_pkg::S_READ: state_d = sts_i.need_scan ? dst_pkg::S_SCAN : dst_pkg::S_DONE;
      dst_pkg::S_SCAN: if (sts_i.scan_done) state_d = dst_pkg::S_DONE;
      dst_pkg::S_DONE: state_d = dst_pkg::S_OUT;
      dst_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = in_valid_i ? dst_pkg::S_READ : dst_pkg::S_IDLE;
        end
      end
      default: state_d = dst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      dst_pkg::S_READ: cmd_o.read = 1'b1;
      dst_pkg::S_SCAN: cmd_o.scan = 1'b1;
      dst_pkg::S_DONE: cmd_o.finish = 1'b1;
      dst_pkg::S_OUT: begin
        out_valid_o   = 1'b1;
        in_ready_o    = out_ready_i;
        cmd_o.out_pop = out_ready_i;
        cmd_o.load    = out_ready_i && in_valid_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/dst_datapath.sv =====
module dst_datapath #(
  parameter int ENTRIES     = 64,
  parameter int FLAG_BITS   = 4,
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dst_pkg::dst_cmd_t      cmd_i,
  output dst_pkg::dst_sts_t      sts_o,
  input  logic [3:0]             opcode_i,
  input  logic signed [15:0]     slot_index_i,
  input  logic signed [15:0]     second_index_i,
  input  logic [HANDLE_BITS-1:0] handle_in_i,
  input  logic [FLAG_BITS-1:0]   flags_in_i,
  input  logic [3:0]             allowed_mask_i,
  input  logic [3:0]             exec_mask_i,
  output logic [1:0]             status_o,
  output logic [11:0]            index_out_o,
  output logic [HANDLE_BITS-1:0] handle_out_o,
  output logic [FLAG_BITS-1:0]   flags_out_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int MW = (FLAG_BITS < 4) ? FLAG_BITS : 4;

  // handle/flags memories, one port each, registered read
  logic [HANDLE_BITS-1:0] hmem [ENTRIES];
  logic [FLAG_BITS-1:0]   fmem [ENTRIES];
  logic [ENTRIES-1:0]     valid_q;
  logic [CW-1:0]          hint_q;

  logic [3:0]             op_q;
  logic signed [15:0]     a_q, b_q;
  logic [HANDLE_BITS-1:0] hin_q;
  logic [FLAG_BITS-1:0]   fin_q;

  logic [HANDLE_BITS-1:0] hrd_q;
  logic [FLAG_BITS-1:0]   frd_q;

  logic [CW-1:0] ptr_q;       // walk pointer; counts up, or down for previous
  logic          found_q;
  logic [IW-1:0] fidx_q;
  logic          any_q;

  logic [1:0]             st_q;
  logic [11:0]            idx_q;
  logic [HANDLE_BITS-1:0] ho_q;
  logic [FLAG_BITS-1:0]   fo_q;

  // memory port addressing
  logic                   mwe;
  logic [IW-1:0]          maddr;
  logic [HANDLE_BITS-1:0] mwh;
  logic [FLAG_BITS-1:0]   mwf;
  logic                   mre;

  logic                   a_in, b_in, a_good, flags_bad;
  logic [IW-1:0]          a_ix, b_ix, ptr_ix;
  logic                   ptr_in;
  logic                   scanning_prev;

  assign a_in   = (a_q >= 0) && (a_q < ENTRIES);
  assign b_in   = (b_q >= 0) && (b_q < ENTRIES);
  assign a_ix   = a_q[IW-1:0];
  assign b_ix   = b_q[IW-1:0];
  assign a_good = a_in && valid_q[a_ix];
  assign flags_bad = |(fin_q & ~FLAG_BITS'(allowed_mask_i[MW-1:0])) ||
                     ((FLAG_BITS > 4) && |(fin_q >> 4));
  assign ptr_in = ptr_q < CW'(ENTRIES);
  assign ptr_ix = ptr_q[IW-1:0];
  assign scanning_prev  = (op_q == dst_pkg::OP_PREV);

  // start point of the walk
  logic [CW-1:0] start;
  always_comb begin
    start = '0;
    case (op_q)
      dst_pkg::OP_ALLOC, dst_pkg::OP_ALLOC_DUP: begin
        if (b_q >= ENTRIES) start = CW'(ENTRIES);
        else if (CW'(b_q[IW:0]) < hint_q) start = hint_q;
        else start = CW'(b_q[IW:0]);
      end
      dst_pkg::OP_NEXT: begin
        if (a_q < 0) start = '0;
        else if (a_q >= ENTRIES) start = CW'(ENTRIES);
        else start = CW'(a_q[IW:0]) + CW'(1);
      end
      dst_pkg::OP_PREV: begin
        // ptr counts slots above the one looked at: look at ptr-1
        if (a_q < 0 || a_q > ENTRIES) start = CW'(ENTRIES);
        else start = CW'(a_q[IW:0]);
      end
      dst_pkg::OP_CLOSE_FROM: begin
        if (a_q >= ENTRIES) start = CW'(ENTRIES);
        else start = CW'(a_q[IW:0]);
      end
      default: start = '0;
    endcase
  end

  logic need_scan;
  always_comb begin
    case (op_q)
      dst_pkg::OP_ALLOC:      need_scan = !flags_bad && (b_q >= 0);
      dst_pkg::OP_ALLOC_DUP:  need_scan = a_good && !flags_bad && (b_q >= 0);
      dst_pkg::OP_NEXT, dst_pkg::OP_PREV: need_scan = 1'b1;
      dst_pkg::OP_CLOSE_FROM: need_scan = (a_q >= 0);
      dst_pkg::OP_EXEC_SWEEP: need_scan = 1'b1;
      default:                need_scan = 1'b0;
    endcase
  end

  // scan step
  logic          cur_in;
  logic [IW-1:0] cur_ix;
  logic          cur_v;
  logic          hit, last;
  always_comb begin
    if (scanning_prev) begin
      cur_in = ptr_q != '0;
      cur_ix = IW'(ptr_q - CW'(1));
    end else begin
      cur_in = ptr_in;
      cur_ix = ptr_ix;
    end
    cur_v = cur_in && valid_q[cur_ix];
    hit   = 1'b0;
    case (op_q)
      dst_pkg::OP_ALLOC, dst_pkg::OP_ALLOC_DUP: hit = cur_in && !valid_q[cur_ix];
      dst_pkg::OP_NEXT, dst_pkg::OP_PREV:       hit = cur_v;
      default:                                  hit = 1'b0;
    endcase
    last = !cur_in || hit ||
           (scanning_prev ? (ptr_q == CW'(1)) : (ptr_q == CW'(ENTRIES - 1)));
  end

  // release step of close_from / exec sweep needs the flags of cur_ix; the
  // flags memory is read in the phase before it, in a two-phase walk
  logic phase_q;
  logic sweep;
  assign sweep = (op_q == dst_pkg::OP_CLOSE_FROM) || (op_q == dst_pkg::OP_EXEC_SWEEP);

  logic rel_now;
  assign rel_now = cmd_i.scan && sweep && phase_q && cur_v &&
                   ((op_q == dst_pkg::OP_CLOSE_FROM) ||
                    |(frd_q & FLAG_BITS'(exec_mask_i[MW-1:0])));

  always_comb begin
    sts_o.need_scan = need_scan;
    if (sweep) sts_o.scan_done = phase_q && (!ptr_in || ptr_q == CW'(ENTRIES - 1));
    else       sts_o.scan_done = last;
  end

  // final decision
  logic [1:0]    f_st;
  logic [IW-1:0] f_idx;
  logic          f_wr;
  logic [IW-1:0] f_waddr;
  logic [HANDLE_BITS-1:0] f_wh;
  logic [FLAG_BITS-1:0]   f_wf;
  logic          f_setv, f_clrv, f_hout, f_fout, f_clear;
  always_comb begin
    f_st = dst_pkg::ST_OK; f_idx = '0; f_wr = 1'b0; f_waddr = a_ix;
    f_wh = hrd_q; f_wf = fin_q; f_setv = 1'b0; f_clrv = 1'b0;
    f_hout = 1'b0; f_fout = 1'b0; f_clear = 1'b0;
    case (op_q)
      dst_pkg::OP_ALLOC, dst_pkg::OP_ALLOC_DUP: begin
        if (op_q == dst_pkg::OP_ALLOC_DUP && !a_good) f_st = dst_pkg::ST_BADF;
        else if (flags_bad || b_q < 0) f_st = dst_pkg::ST_INVAL;
        else if (!found_q) f_st = dst_pkg::ST_FULL;
        else begin
          f_idx = fidx_q; f_wr = 1'b1; f_waddr = fidx_q; f_setv = 1'b1;
          if (op_q == dst_pkg::OP_ALLOC) f_wh = hin_q;
        end
      end
      dst_pkg::OP_COPY_TO: begin
        if (flags_bad || a_q < 0 || b_q < 0) f_st = dst_pkg::ST_INVAL;
        else if (!a_good) f_st = dst_pkg::ST_BADF;
        else if (a_q == b_q) f_st = dst_pkg::ST_INVAL;
        else if (!b_in) f_st = dst_pkg::ST_FULL;
        else begin
          f_idx = b_ix; f_wr = 1'b1; f_waddr = b_ix; f_setv = 1'b1;
        end
      end
      dst_pkg::OP_FREE: begin
        if (!a_good) f_st = dst_pkg::ST_BADF;
        else begin f_hout = 1'b1; f_clrv = 1'b1; end
      end
      dst_pkg::OP_GET: begin
        if (!a_good) f_st = dst_pkg::ST_BADF;
        else f_hout = 1'b1;
      end
      dst_pkg::OP_SET_FLAGS: begin
        if (flags_bad) f_st = dst_pkg::ST_INVAL;
        else if (!a_good) f_st = dst_pkg::ST_BADF;
        else begin f_wr = 1'b1; f_waddr = a_ix; end
      end
      dst_pkg::OP_GET_FLAGS: begin
        if (!a_good) f_st = dst_pkg::ST_BADF;
        else f_fout = 1'b1;
      end
      dst_pkg::OP_NEXT, dst_pkg::OP_PREV: begin
        if (!found_q) f_st = dst_pkg::ST_BADF;
        else f_idx = fidx_q;
      end
      dst_pkg::OP_CLOSE_FROM: begin
        if (a_q < 0 || !any_q) f_st = dst_pkg::ST_BADF;
      end
      dst_pkg::OP_EXEC_SWEEP: f_st = dst_pkg::ST_OK;
      dst_pkg::OP_CLEAR_ALL:  f_clear = 1'b1;
      default: f_st = dst_pkg::ST_INVAL;
    endcase
  end

  // memory port: one access per cycle
  always_comb begin
    mwe = 1'b0; maddr = a_ix; mwh = f_wh; mwf = f_wf; mre = 1'b0;
    if (cmd_i.read) begin
      mre = 1'b1;
    end else if (cmd_i.scan && sweep && !phase_q) begin
      mre = 1'b1; maddr = ptr_ix;
    end else if (cmd_i.finish && f_wr) begin
      mwe = 1'b1; maddr = f_waddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      hmem[maddr] <= mwh;
      fmem[maddr] <= mwf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mre) begin
      hrd_q <= hmem[maddr];
      frd_q <= fmem[maddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      a_q   <= slot_index_i;
      b_q   <= second_index_i;
      hin_q <= handle_in_i;
      fin_q <= flags_in_i;
    end
    if (cmd_i.finish) begin
      st_q  <= f_st;
      idx_q <= 12'(f_idx);
      ho_q  <= (f_st == dst_pkg::ST_OK && f_hout) ? hrd_q : '0;
      fo_q  <= (f_st == dst_pkg::ST_OK && f_fout) ? frd_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hint_q  <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      any_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        ptr_q   <= start;
        found_q <= 1'b0;
        any_q   <= 1'b0;
        phase_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (sweep) begin
          phase_q <= !phase_q;
          if (phase_q) begin
            ptr_q <= ptr_q + CW'(1);
            if (rel_now) begin
              valid_q[cur_ix] <= 1'b0;
              any_q <= 1'b1;
              if (CW'(cur_ix) < hint_q) hint_q <= CW'(cur_ix);
            end
          end
        end else begin
          if (hit) begin
            found_q <= 1'b1;
            fidx_q  <= cur_ix;
          end
          if (scanning_prev) ptr_q <= ptr_q - CW'(1);
          else ptr_q <= ptr_q + CW'(1);
        end
      end
      if (cmd_i.finish && f_st == dst_pkg::ST_OK) begin
        if (f_clear) begin
          valid_q <= '0;
          hint_q  <= '0;
        end
        if (f_setv) begin
          valid_q[f_waddr] <= 1'b1;
          if (hint_q == CW'(f_waddr)) hint_q <= CW'(f_waddr) + CW'(1);
        end
        if (f_clrv) begin
          valid_q[a_ix] <= 1'b0;
          if (CW'(a_ix) < hint_q) hint_q <= CW'(a_ix);
        end
      end
    end
  end

  assign status_o     = st_q;
  assign index_out_o  = idx_q;
  assign handle_out_o = ho_q;
  assign flags_out_o  = fo_q;

endmodule

// ===== rtl/core/descriptor_slot_table_unit.sv =====
// Channel  | Signals                           | Direction
// s_axis   | s_axis_tvalid/tready/tdata        | item in
// m_axis   | m_axis_tvalid/tready/tdata        | result out
// apb      | psel/penable/pwrite/paddr/pwdata  | register access
//
// Lookup opcodes go through three steps an item: read, finish, result.
// Searches and allocation walk one slot a cycle; sweeps give each slot a read
// phase and a release phase, since the slot memory has a single port.
// Reset clears valid bits, hint and control; memory contents stay undefined.
// A new item is taken in the cycle the result is taken.
module descriptor_slot_table_unit #(
  parameter int ENTRIES     = 64,
  parameter int FLAG_BITS   = 4,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[3:0], slot_index[19:4], second_index[35:20], handle_in, flags_in
  input  logic [((4+32+HANDLE_BITS+FLAG_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], index_out[13:2], handle_out, flags_out
  output logic [((14+HANDLE_BITS+FLAG_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OBITS = 14 + HANDLE_BITS + FLAG_BITS;
  localparam int OW    = ((OBITS + 7) / 8) * 8;

  logic [3:0] allowed_q, exec_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= 4'd3;
      exec_q    <= 4'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == {dst_pkg::REG_ALLOWED, 2'b00}) allowed_q <= pwdata[3:0];
      if (paddr == {dst_pkg::REG_EXEC, 2'b00})    exec_q    <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == {dst_pkg::REG_ALLOWED, 2'b00}) prdata = {28'd0, allowed_q};
    else if (paddr == {dst_pkg::REG_EXEC, 2'b00}) prdata = {28'd0, exec_q};
  end

  dst_pkg::dst_cmd_t cmd;
  dst_pkg::dst_sts_t sts;

  logic [1:0]             status;
  logic [11:0]            index_out;
  logic [HANDLE_BITS-1:0] handle_out;
  logic [FLAG_BITS-1:0]   flags_out;

  dst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dst_datapath #(
    .ENTRIES     (ENTRIES),
    .FLAG_BITS   (FLAG_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (s_axis_tdata[3:0]),
    .slot_index_i   (s_axis_tdata[19:4]),
    .second_index_i (s_axis_tdata[35:20]),
    .handle_in_i    (s_axis_tdata[36 +: HANDLE_BITS]),
    .flags_in_i     (s_axis_tdata[36+HANDLE_BITS +: FLAG_BITS]),
    .allowed_mask_i (allowed_q),
    .exec_mask_i    (exec_q),
    .status_o       (status),
    .index_out_o    (index_out),
    .handle_out_o   (handle_out),
    .flags_out_o    (flags_out)
  );

  assign m_axis_tdata = OW'({flags_out, handle_out, index_out, status});

endmodule

// ===== tb/sv/tb_descriptor_slot_table_unit.sv =====
module tb_descriptor_slot_table_unit;

  localparam int ENTRIES = 64;

  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] handle;
    logic [15:0] second;
    logic [15:0] slot;
    logic [3:0]  op;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] index;
    logic [31:0] handle;
    logic [3:0]  flags;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  descriptor_slot_table_unit i_dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_handle[ENTRIES];
  logic [3:0]  tbl_flags [ENTRIES];
  int          low_hint;
  logic [3:0]  allow_mask = 4'd3;
  logic [3:0]  exec_mask = 4'd1;

  req_t  pending_items[$];
  resp_t expected_resps[$];
  int    errors = 0;
  bit    noidle = 1'b0;
  int    hold_rx = 0;

  function automatic void free_slot(int i);
    tbl_valid[i] = 1'b0;
    tbl_flags[i] = '0;
    if (i < low_hint) low_hint = i;
  endfunction

  function automatic logic [1:0] take_slot(logic [31:0] h, logic [3:0] f, int mn,
                                           ref int where);
    if ((f & ~allow_mask) != 0 || mn < 0) return dst_pkg::ST_INVAL;
    if (mn < low_hint) mn = low_hint;
    for (int i = mn; i < ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_handle[i] = h;
        tbl_flags[i] = f;
        if (low_hint == i) low_hint = i + 1;
        where = i;
        return dst_pkg::ST_OK;
      end
    end
    return dst_pkg::ST_FULL;
  endfunction

  function automatic bit live(int i);
    return i >= 0 && i < ENTRIES && tbl_valid[i];
  endfunction

  function automatic resp_t table_step(req_t r);
    resp_t o;
    int a, b, idx;
    logic [1:0] st;
    logic [31:0] hout;
    logic [3:0] fout;
    bit any;
    a = $signed(r.slot);
    b = $signed(r.second);
    idx = 0; hout = '0; fout = '0; st = dst_pkg::ST_OK;
    case (r.op)
      dst_pkg::OP_ALLOC: st = take_slot(r.handle, r.flags, b, idx);
      dst_pkg::OP_ALLOC_DUP:
        if (!live(a)) st = dst_pkg::ST_BADF;
        else st = take_slot(tbl_handle[a], r.flags, b, idx);
      dst_pkg::OP_COPY_TO:
        if ((r.flags & ~allow_mask) != 0 || a < 0 || b < 0) st = dst_pkg::ST_INVAL;
        else if (a >= ENTRIES || !tbl_valid[a]) st = dst_pkg::ST_BADF;
        else if (a == b) st = dst_pkg::ST_INVAL;
        else if (b >= ENTRIES) st = dst_pkg::ST_FULL;
        else begin
          tbl_valid[b] = 1'b1;
          tbl_handle[b] = tbl_handle[a];
          tbl_flags[b] = r.flags;
          if (low_hint == b) low_hint = b + 1;
          idx = b;
        end
      dst_pkg::OP_FREE:
        if (!live(a)) st = dst_pkg::ST_BADF;
        else begin
          hout = tbl_handle[a];
          free_slot(a);
        end
      dst_pkg::OP_GET: if (!live(a)) st = dst_pkg::ST_BADF; else hout = tbl_handle[a];
      dst_pkg::OP_SET_FLAGS:
        if ((r.flags & ~allow_mask) != 0) st = dst_pkg::ST_INVAL;
        else if (!live(a)) st = dst_pkg::ST_BADF;
        else tbl_flags[a] = r.flags;
      dst_pkg::OP_GET_FLAGS: if (!live(a)) st = dst_pkg::ST_BADF; else fout = tbl_flags[a];
      dst_pkg::OP_NEXT: begin
        if (a < 0) a = -1;
        st = dst_pkg::ST_BADF;
        if (a < ENTRIES)
          for (int i = a + 1; i < ENTRIES; i++)
            if (tbl_valid[i]) begin idx = i; st = dst_pkg::ST_OK; break; end
      end
      dst_pkg::OP_PREV: begin
        if (a < 0 || a > ENTRIES) a = ENTRIES;
        st = dst_pkg::ST_BADF;
        for (int i = a - 1; i >= 0; i--)
          if (tbl_valid[i]) begin idx = i; st = dst_pkg::ST_OK; break; end
      end
      dst_pkg::OP_CLOSE_FROM:
        if (a < 0) st = dst_pkg::ST_BADF;
        else begin
          any = 0;
          for (int i = a; i < ENTRIES; i++)
            if (tbl_valid[i]) begin free_slot(i); any = 1; end
          st = any ? dst_pkg::ST_OK : dst_pkg::ST_BADF;
        end
      dst_pkg::OP_EXEC_SWEEP:
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_valid[i] && (tbl_flags[i] & exec_mask) != 0) free_slot(i);
      dst_pkg::OP_CLEAR_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_flags[i] = '0;
        end
        low_hint = 0;
      end
      default: st = dst_pkg::ST_INVAL;
    endcase
    if (st != dst_pkg::ST_OK) begin idx = 0; hout = '0; fout = '0; end
    o.status = st; o.index = idx[11:0]; o.handle = hout; o.flags = fout;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resps.push_back(table_step(pending_items.pop_front()));
      end
      if ((!s_axis_tvalid || s_axis_tready) || !s_axis_tvalid) begin
        if (s_axis_tvalid && !s_axis_tready) begin
          // hold the offered item
        end else if (pending_items.size() > 0 &&
                     (noidle || $urandom_range(99) >= 12)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_items[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    resp_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.index = m_axis_tdata[13:2];
        got.handle = m_axis_tdata[45:14];
        got.flags = m_axis_tdata[49:46];
        if (expected_resps.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
          if (got.index !== want.index) begin
            $error("index_out exp %0d got %0d", want.index, got.index); errors++;
          end
          if (got.handle !== want.handle) begin
            $error("handle_out exp %h got %h", want.handle, got.handle); errors++;
          end
          if (got.flags !== want.flags) begin
            $error("flags_out exp %h got %h", want.flags, got.flags); errors++;
          end
        end
      end
      if (hold_rx > 0) begin
        hold_rx <= hold_rx - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= noidle || $urandom_range(99) >= 12;
      end
    end
  end

  task automatic wait_drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (2 * ENTRIES + 20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) allow_mask = val[3:0]; else exec_mask = val[3:0];
    @(posedge clk_i);
  endtask

  task automatic add_item(dst_pkg::opcode_e op, int a, int b, logic [31:0] h,
                          logic [3:0] f);
    req_t r;
    r.op = op; r.slot = a[15:0]; r.second = b[15:0]; r.handle = h; r.flags = f;
    pending_items.push_back(r);
  endtask

  function automatic int pick_slot();
    case ($urandom_range(9))
      0: return $signed(16'($urandom));
      1: return $urandom_range(ENTRIES + 3, ENTRIES - 1);
      2: return -$urandom_range(3, 1);
      default: return $urandom_range(ENTRIES - 1);
    endcase
  endfunction

  task automatic add_random(int n);
    req_t r;
    int a, b;
    for (int k = 0; k < n; k++) begin
      a = pick_slot();
      b = ($urandom_range(3) == 0) ? pick_slot() : $urandom_range(15);
      r.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) :
             ($urandom_range(2) == 0) ? 4'(dst_pkg::OP_ALLOC) : 4'($urandom_range(9));
      if ($urandom_range(60) == 0) r.op = 4'($urandom_range(11, 10));
      r.slot = a[15:0]; r.second = b[15:0]; r.handle = $urandom;
      r.flags = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom) & allow_mask;
      pending_items.push_back(r);
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_handle[i] = '0; tbl_flags[i] = '0;
    end
    low_hint = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(3'd0, 32'hF);
    reg_write(3'd4, 32'h8);
    // directed corners
    add_item(dst_pkg::OP_ALLOC, 0, 0, 32'hFFFF_FFFF, 4'hF);
    add_item(dst_pkg::OP_ALLOC, 0, -1, 32'h0, 4'h0);
    add_item(dst_pkg::OP_ALLOC, 0, ENTRIES, 32'h1, 4'h0);
    add_item(dst_pkg::OP_ALLOC, 0, ENTRIES - 1, 32'h1234, 4'h8);
    add_item(dst_pkg::OP_ALLOC_DUP, 0, 5, 32'h0, 4'h1);
    add_item(dst_pkg::OP_ALLOC_DUP, 7, 0, 32'h0, 4'h1);
    add_item(dst_pkg::OP_COPY_TO, 0, 0, 32'h0, 4'h2);
    add_item(dst_pkg::OP_COPY_TO, 0, ENTRIES, 32'h0, 4'h2);
    add_item(dst_pkg::OP_COPY_TO, 0, 5, 32'h0, 4'h4);
    add_item(dst_pkg::OP_COPY_TO, -32768, 32767, 32'h0, 4'h0);
    add_item(dst_pkg::OP_GET, 5, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_GET_FLAGS, 5, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_SET_FLAGS, 5, 0, 32'h0, 4'h9);
    add_item(dst_pkg::OP_NEXT, -5, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_NEXT, ENTRIES, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_PREV, 32767, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_PREV, -1, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_FREE, 0, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_EXEC_SWEEP, 0, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_CLOSE_FROM, -1, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_CLOSE_FROM, 1, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_CLOSE_FROM, 0, 0, 32'h0, 4'h0);
    add_item(dst_pkg::OP_CLEAR_ALL, 0, 0, 32'h0, 4'h0);
    add_item(dst_pkg::opcode_e'(4'd15), 0, 0, 32'h0, 4'h0);
    wait_drain();
    reg_write(3'd0, 32'd3);
    reg_write(3'd4, 32'd1);
    add_random(500);
    hold_rx = 300;
    wait_drain();
    reg_write(3'd0, 32'd0);
    reg_write(3'd4, 32'hF);
    add_random(400);
    wait_drain();
    reg_write(3'd0, 32'hF);
    reg_write(3'd4, 32'd0);
    noidle = 1'b1;
    add_random(500);
    wait_drain();
    noidle = 1'b0;
    reg_write(3'd0, 32'd5);
    reg_write(3'd4, 32'd6);
    add_random(500);
    wait_drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/dst_pkg.sv
rtl/core/dst_ctrl.sv
rtl/core/dst_datapath.sv
rtl/core/descriptor_slot_table_unit.sv
tb/sv/tb_descriptor_slot_table_unit.sv
